[rtl/keyed_list_insert_remove_find_macros.svh]
// Assertion macros for the keyed list block
`ifndef KEYED_LIST_INSERT_REMOVE_FIND_MACROS_SVH
`define KEYED_LIST_INSERT_REMOVE_FIND_MACROS_SVH

`ifndef SYNTHESIS
`define KL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("keyed list check failed");
`define KL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("keyed list check failed");
`else
`define KL_ASSERT_NOW(label, clk, rst, ante, cons)
`define KL_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[rtl/klist_pkg.sv]
// Shared types and codes of the keyed list block
`timescale 1ns / 1ps
`default_nettype none
package klist_pkg;

   localparam int unsigned CAPACITY_DEF = 16;

   localparam logic [1:0] ACT_ADD    = 2'd0;
   localparam logic [1:0] ACT_REMOVE = 2'd1;
   localparam logic [1:0] ACT_SEARCH = 2'd2;

   localparam logic [2:0] ST_ADDED   = 3'd0;
   localparam logic [2:0] ST_FULL    = 3'd1;
   localparam logic [2:0] ST_REMOVED = 3'd2;
   localparam logic [2:0] ST_MISSING = 3'd3;
   localparam logic [2:0] ST_EMPTY   = 3'd4;
   localparam logic [2:0] ST_FOUND   = 3'd5;

   typedef struct packed {
      logic [63:0]        name;
      logic [63:0]        kind;
      logic signed [31:0] amount;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ADD,
      S_READ,
      S_CMP,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_DONE
   } state_type;

endpackage
`default_nettype wire

[rtl/klist_if.sv]
// Request and response channel interfaces of the keyed list block
`timescale 1ns / 1ps
`default_nettype none
interface klist_req_if import klist_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [1:0]         action;
   logic [63:0]        item_name;
   logic [63:0]        item_kind;
   logic signed [31:0] item_amount;

   modport source (output valid, output action, output item_name, output item_kind,
                   output item_amount, input ready);
   modport sink (input valid, input action, input item_name, input item_kind,
                 input item_amount, output ready);
endinterface

interface klist_rsp_if import klist_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [2:0]         status;
   logic [4:0]         found_position;
   logic [63:0]        found_kind;
   logic signed [31:0] found_amount;
   logic [4:0]         entries_in_use;

   modport source (output valid, output status, output found_position, output found_kind,
                   output found_amount, output entries_in_use, input ready);
   modport sink (input valid, input status, input found_position, input found_kind,
                 input found_amount, input entries_in_use, output ready);
endinterface
`default_nettype wire

[rtl/klist_store.sv]
// Entry memory: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none
module klist_store import klist_pkg::*; #(
   parameter int unsigned CAPACITY = CAPACITY_DEF,
   parameter int unsigned IDX_W = 4
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [IDX_W-1:0] wr_addr,
   input  wire entry_type        wr_data,
   input  wire logic [IDX_W-1:0] rd_addr,
   output entry_type             rd_data
);

   entry_type mem [CAPACITY];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[rtl/keyed_list_insert_remove_find.sv]
// Top level of the keyed list: sequencer, request latch and response register
//
//  channel  | direction | handshake     | payload
//  req_ch   | in        | valid/ready   | action, item_name, item_kind, item_amount
//  rsp_ch   | out       | valid/ready   | status, found_position, found_kind,
//           |           |               | found_amount, entries_in_use
//
// Add writes at the fill index unless full; search reads each entry, then compares it;
// remove then shifts each later entry down one place, a read and then a write, as the
// entry memory has a single read port. Visited plus shifted never exceed the count.
// Reset clears the sequencer, response valid and entry count; memory is not cleared.
// One finished transaction waits in the response register while the next
// request is accepted; a later result waits in the done state until it frees.
`timescale 1ns / 1ps
`default_nettype none
`include "keyed_list_insert_remove_find_macros.svh"
module keyed_list_insert_remove_find import klist_pkg::*; #(
   parameter int unsigned CAPACITY = CAPACITY_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   klist_req_if.sink   req_ch,
   klist_rsp_if.source rsp_ch
);

   localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

   state_type state_ff, state_in;

   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   logic [1:0]         act_ff, act_in;
   logic [63:0]        key_ff, key_in;
   logic [63:0]        kind_ff, kind_in;
   logic signed [31:0] amount_ff, amount_in;

   logic [2:0]         res_status_ff, res_status_in;
   logic [4:0]         res_pos_ff, res_pos_in;
   logic [63:0]        res_kind_ff, res_kind_in;
   logic signed [31:0] res_amount_ff, res_amount_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_status_ff, rsp_status_in;
   logic [4:0]         rsp_pos_ff, rsp_pos_in;
   logic [63:0]        rsp_kind_ff, rsp_kind_in;
   logic signed [31:0] rsp_amount_ff, rsp_amount_in;
   logic [4:0]         rsp_count_ff, rsp_count_in;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;
   logic [IDX_W-1:0] rd_addr;
   entry_type        rd_data;

   logic        req_take;
   logic        rsp_free;
   logic        is_full;
   logic        at_last;
   logic        shift_last;
   logic        hit;
   logic [31:0] pos32;
   logic [31:0] cnt32;

   klist_store #(
      .CAPACITY (CAPACITY),
      .IDX_W    (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;
   assign is_full      = (fill_ff == CNT_W'(CAPACITY));
   assign at_last      = (32'(idx_ff) + 32'd1 == 32'(fill_ff));
   assign shift_last   = (32'(idx_ff) + 32'd2 == 32'(fill_ff));
   assign hit          = (rd_data.name == key_ff);
   assign pos32        = 32'(idx_ff) + 32'd1;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               case (req_ch.action)
                  ACT_ADD: state_in = S_ADD;
                  ACT_REMOVE, ACT_SEARCH: begin
                     state_in = (fill_ff == '0) ? S_DONE : S_READ;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_ADD: state_in = S_DONE;
         S_READ: state_in = S_CMP;
         S_CMP: begin
            if (hit) begin
               if (act_ff == ACT_REMOVE && !at_last) begin
                  state_in = S_SHIFT_RD;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               state_in = at_last ? S_DONE : S_READ;
            end
         end
         S_SHIFT_RD: state_in = S_SHIFT_WR;
         S_SHIFT_WR: state_in = shift_last ? S_DONE : S_SHIFT_RD;
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      fill_in       = fill_ff;
      idx_in        = idx_ff;
      act_in        = act_ff;
      key_in        = key_ff;
      kind_in       = kind_ff;
      amount_in     = amount_ff;
      res_status_in = res_status_ff;
      res_pos_in    = res_pos_ff;
      res_kind_in   = res_kind_ff;
      res_amount_in = res_amount_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_amount_in = rsp_amount_ff;
      rsp_count_in  = rsp_count_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = rd_data;
      rd_addr       = idx_ff;
      cnt32         = 32'(fill_ff);
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               act_in        = req_ch.action;
               key_in        = req_ch.item_name;
               kind_in       = req_ch.item_kind;
               amount_in     = req_ch.item_amount;
               idx_in        = '0;
               res_pos_in    = '0;
               res_kind_in   = '0;
               res_amount_in = '0;
               res_status_in = ST_MISSING;
               if ((req_ch.action == ACT_REMOVE || req_ch.action == ACT_SEARCH)
                   && fill_ff == '0) begin
                  res_status_in = ST_EMPTY;
               end
            end
         end
         S_ADD: begin
            if (is_full) begin
               res_status_in = ST_FULL;
            end else begin
               wr_en         = 1'b1;
               wr_addr       = fill_ff[IDX_W-1:0];
               wr_data       = '{name: key_ff, kind: kind_ff, amount: amount_ff};
               fill_in       = fill_ff + CNT_W'(1);
               res_status_in = ST_ADDED;
            end
         end
         S_CMP: begin
            if (hit) begin
               res_pos_in    = pos32[4:0];
               res_kind_in   = rd_data.kind;
               res_amount_in = rd_data.amount;
               if (act_ff == ACT_REMOVE) begin
                  res_status_in = ST_REMOVED;
                  if (at_last) begin
                     fill_in = fill_ff - CNT_W'(1);
                  end
               end else begin
                  res_status_in = ST_FOUND;
               end
            end else if (!at_last) begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         S_SHIFT_RD: begin
            rd_addr = idx_ff + IDX_W'(1);
         end
         S_SHIFT_WR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_data = rd_data;
            idx_in  = idx_ff + IDX_W'(1);
            if (shift_last) begin
               fill_in = fill_ff - CNT_W'(1);
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_pos_in    = res_pos_ff;
               rsp_kind_in   = res_kind_ff;
               rsp_amount_in = res_amount_ff;
               rsp_count_in  = cnt32[4:0];
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      act_ff        <= act_in;
      key_ff        <= key_in;
      kind_ff       <= kind_in;
      amount_ff     <= amount_in;
      res_status_ff <= res_status_in;
      res_pos_ff    <= res_pos_in;
      res_kind_ff   <= res_kind_in;
      res_amount_ff <= res_amount_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_amount_ff <= rsp_amount_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_status_ff;
   assign rsp_ch.found_position = rsp_pos_ff;
   assign rsp_ch.found_kind     = rsp_kind_ff;
   assign rsp_ch.found_amount   = rsp_amount_ff;
   assign rsp_ch.entries_in_use = rsp_count_ff;

   `KL_ASSERT_NOW(a_fill_bound, clock, reset, 1'b1, 32'(fill_ff) <= 32'(CAPACITY))
   `KL_ASSERT_NOW(a_write_in_range, clock, reset, wr_en, 32'(wr_addr) <= 32'(fill_ff))
   `KL_ASSERT_NEXT(a_fill_step, clock, reset, 1'b1,
      fill_ff == $past(fill_ff) || fill_ff == $past(fill_ff) + CNT_W'(1) ||
      fill_ff == $past(fill_ff) - CNT_W'(1))
   `KL_ASSERT_NEXT(a_done_loads_rsp, clock, reset, state_ff == S_DONE && rsp_free, rsp_valid_ff)

endmodule
`default_nettype wire
